@@ rtl/srsw_pkg.sv @@
// shared types and constants of the selective-repeat sender window
// no dependencies; used by every module of the block
package srsw_pkg;

   localparam int MAX_WINDOW   = 16;
   localparam int SLOT_W       = $clog2(MAX_WINDOW);
   localparam int WLEN_W       = SLOT_W + 1;
   localparam int PACKET_BYTES = 4096;
   localparam int NUM_W        = 20;
   localparam int CNT_W        = 21;
   localparam int SIZE_W       = 13;
   localparam int TIME_W       = 32;
   localparam int LEN_W        = 32;
   localparam int FUNC_W       = 2;
   localparam int CSR_IDX_W    = 2;

   localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ACK   = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_LEN   = 2'd2;

   localparam logic KIND_SEND   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [LEN_W-1:0] PKT_BYTES_L = LEN_W'(PACKET_BYTES);

   typedef enum logic [1:0] {
      EV_START,
      EV_ACK,
      EV_POLL
   } event_type;

   typedef struct packed {
      event_type         ev;
      logic [NUM_W-1:0]  ack_seq;
      logic [TIME_W-1:0] now;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [NUM_W-1:0]  pkt_seq;
      logic [SIZE_W-1:0] pkt_len;
      logic              is_end;
      logic              retransmit;
      logic [CNT_W-1:0]  base_number;
      logic              mismatch;
      logic              done_res;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [4:0]        win_size;
      logic [TIME_W-1:0] timeout_ticks;
      logic [LEN_W-1:0]  total_length;
   } cfg_type;

endpackage

@@ rtl/srsw_req_q.sv @@
// front end: takes event words, decodes the event kind, holds two of them
// depends on srsw_pkg
module srsw_req_q (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [srsw_pkg::FUNC_W-1:0]    func,
   input  logic [srsw_pkg::NUM_W-1:0]     ack_seq,
   input  logic [srsw_pkg::TIME_W-1:0]    now,
   output logic                           out_valid,
   output srsw_pkg::req_type              out_word,
   input  logic                           out_pop
);

   srsw_pkg::req_type mem_ff [2];
   srsw_pkg::req_type word_in;
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              do_push;
   logic              do_pop;

   always_comb begin
      word_in.ack_seq = ack_seq;
      word_in.now     = now;
      unique case (func)
         srsw_pkg::FUNC_START: word_in.ev = srsw_pkg::EV_START;
         srsw_pkg::FUNC_ACK:   word_in.ev = srsw_pkg::EV_ACK;
         default:              word_in.ev = srsw_pkg::EV_POLL;   // unused code polls
      endcase
   end

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_word  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = out_pop && out_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= word_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

endmodule

@@ rtl/srsw_rsp_q.sv @@
// result queue: two words between the engine and the result ports
// depends on srsw_pkg
module srsw_rsp_q (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  srsw_pkg::rsp_type in_word,
   output logic              full,
   output logic              empty,
   output srsw_pkg::rsp_type out_word,
   input  logic              pop
);

   srsw_pkg::rsp_type mem_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign out_word = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= in_word;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

endmodule

@@ rtl/srsw_engine.sv @@
// back end: window state, ack marking, slide, refill and send scan, one slot a cycle
// unless a full result queue holds the scan; depends on srsw_pkg
module srsw_engine (
   input  logic              clock,
   input  logic              reset,
   input  srsw_pkg::cfg_type cfg,
   input  logic              req_valid,
   input  srsw_pkg::req_type req_word,
   output logic              req_pop,
   output logic              rsp_push,
   output srsw_pkg::rsp_type rsp_word,
   input  logic              rsp_full
);

   localparam int SW = srsw_pkg::SLOT_W;
   localparam int LW = srsw_pkg::WLEN_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLIDE,
      ST_REFILL,
      ST_SCAN_INIT,
      ST_SCAN,
      ST_STATUS
   } state_type;

   state_type                          state_ff;
   logic                               acked_ff [srsw_pkg::MAX_WINDOW];
   logic                               sent_ff  [srsw_pkg::MAX_WINDOW];
   logic [srsw_pkg::TIME_W-1:0]        time_ff  [srsw_pkg::MAX_WINDOW];
   logic [srsw_pkg::NUM_W-1:0]         num_ff   [srsw_pkg::MAX_WINDOW];
   logic [srsw_pkg::SIZE_W-1:0]        size_ff  [srsw_pkg::MAX_WINDOW];
   logic                               end_ff   [srsw_pkg::MAX_WINDOW];
   logic [SW-1:0]                      head_ff;
   logic [SW-1:0]                      tail_ff;
   logic [SW-1:0]                      scan_ff;
   logic                               active_ff;
   logic [srsw_pkg::CNT_W-1:0]         base_ff;
   logic [srsw_pkg::CNT_W-1:0]         next_pkt_ff;
   logic [srsw_pkg::LEN_W-1:0]         bytes_left_ff;
   logic [LW-1:0]                      win_len_ff;
   logic                               started_ff;
   logic                               mis_ff;
   logic [srsw_pkg::TIME_W-1:0]        now_ff;

   logic [LW-1:0]                      win_len_in;
   logic [srsw_pkg::NUM_W-1:0]         ack_dist;
   logic [LW-1:0]                      win_count;
   logic [LW:0]                        ack_sum;
   logic [SW-1:0]                      ack_slot;
   logic [SW-1:0]                      head_next_in;
   logic [SW-1:0]                      tail_next_in;
   logic [SW-1:0]                      scan_next_in;
   logic [srsw_pkg::LEN_W-1:0]         pkt_size_in;
   logic [srsw_pkg::LEN_W-1:0]         bytes_after_in;
   logic                               scan_due;
   logic [srsw_pkg::TIME_W-1:0]        elapsed;

   function automatic logic [SW-1:0] step_idx(input logic [SW-1:0] i, input logic [LW-1:0] len);
      logic [LW-1:0] n;
      n = {1'b0, i} + LW'(1);
      step_idx = (n >= len) ? '0 : n[SW-1:0];
   endfunction

   always_comb begin
      if (cfg.win_size == 5'd0) begin
         win_len_in = LW'(1);
      end else if (cfg.win_size > 5'(srsw_pkg::MAX_WINDOW)) begin
         win_len_in = LW'(srsw_pkg::MAX_WINDOW);
      end else begin
         win_len_in = LW'(cfg.win_size);
      end
   end

   always_comb begin
      ack_dist = req_word.ack_seq - base_ff[srsw_pkg::NUM_W-1:0];
      if (!active_ff) begin
         win_count = '0;
      end else if (tail_ff >= head_ff) begin
         win_count = LW'({1'b0, tail_ff} - {1'b0, head_ff}) + LW'(1);
      end else begin
         win_count = LW'({1'b0, tail_ff} + win_len_ff - {1'b0, head_ff}) + LW'(1);
      end
      // distance is below the count here, so one subtract wraps it
      ack_sum = {2'b00, head_ff} + (LW+1)'(ack_dist[LW-1:0]);
      if (ack_sum >= {1'b0, win_len_ff}) begin
         ack_slot = SW'(ack_sum - {1'b0, win_len_ff});
      end else begin
         ack_slot = ack_sum[SW-1:0];
      end
   end

   assign head_next_in   = step_idx(head_ff, win_len_ff);
   assign tail_next_in   = step_idx(tail_ff, win_len_ff);
   assign scan_next_in   = step_idx(scan_ff, win_len_ff);
   assign pkt_size_in    = (bytes_left_ff > srsw_pkg::PKT_BYTES_L) ? srsw_pkg::PKT_BYTES_L
                                                                   : bytes_left_ff;
   assign bytes_after_in = bytes_left_ff - pkt_size_in;
   assign elapsed        = now_ff - time_ff[scan_ff];
   assign scan_due       = !acked_ff[scan_ff] &&
                           (!sent_ff[scan_ff] || (elapsed >= cfg.timeout_ticks));

   always_comb begin
      rsp_word = '0;
      rsp_word.base_number = base_ff;
      rsp_push = 1'b0;
      if (state_ff == ST_SCAN) begin
         rsp_word.kind       = srsw_pkg::KIND_SEND;
         rsp_word.pkt_seq    = num_ff[scan_ff];
         rsp_word.pkt_len    = size_ff[scan_ff];
         rsp_word.is_end     = end_ff[scan_ff];
         rsp_word.retransmit = sent_ff[scan_ff];
         rsp_push            = scan_due && !rsp_full;
      end else if (state_ff == ST_STATUS) begin
         rsp_word.kind     = srsw_pkg::KIND_STATUS;
         rsp_word.mismatch = mis_ff;
         rsp_word.done_res = started_ff && !active_ff && (bytes_left_ff == '0);
         rsp_word.last     = 1'b1;
         rsp_push          = !rsp_full;
      end
   end

   assign req_pop = (state_ff == ST_IDLE) && req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         scan_ff       <= '0;
         active_ff     <= 1'b0;
         base_ff       <= '0;
         next_pkt_ff   <= '0;
         bytes_left_ff <= '0;
         win_len_ff    <= LW'(1);
         started_ff    <= 1'b0;
         mis_ff        <= 1'b0;
         for (int k = 0; k < srsw_pkg::MAX_WINDOW; k++) begin
            acked_ff[k] <= 1'b0;
            sent_ff[k]  <= 1'b0;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  now_ff <= req_word.now;
                  mis_ff <= 1'b0;
                  unique case (req_word.ev)
                     srsw_pkg::EV_START: begin
                        win_len_ff    <= win_len_in;
                        for (int k = 0; k < srsw_pkg::MAX_WINDOW; k++) begin
                           acked_ff[k] <= 1'b0;
                           sent_ff[k]  <= 1'b0;
                        end
                        head_ff       <= '0;
                        tail_ff       <= '0;
                        active_ff     <= 1'b0;
                        base_ff       <= '0;
                        next_pkt_ff   <= '0;
                        bytes_left_ff <= cfg.total_length;
                        started_ff    <= 1'b1;
                        state_ff      <= ST_REFILL;
                     end
                     srsw_pkg::EV_ACK: begin
                        if ({{(srsw_pkg::NUM_W-LW){1'b0}}, win_count} > ack_dist) begin
                           acked_ff[ack_slot] <= 1'b1;
                           state_ff           <= ST_SLIDE;
                        end else begin
                           mis_ff   <= 1'b1;
                           state_ff <= ST_SCAN_INIT;
                        end
                     end
                     default: state_ff <= ST_SCAN_INIT;
                  endcase
               end
            end
            ST_SLIDE: begin
               if (!active_ff) begin
                  state_ff <= ST_REFILL;
               end else if (head_ff != tail_ff && acked_ff[head_ff]) begin
                  base_ff <= base_ff + srsw_pkg::CNT_W'(1);
                  head_ff <= head_next_in;
               end else begin
                  // last slot acked empties the window
                  if (acked_ff[head_ff]) begin
                     active_ff <= 1'b0;
                     base_ff   <= base_ff + srsw_pkg::CNT_W'(1);
                  end
                  state_ff <= ST_REFILL;
               end
            end
            ST_REFILL: begin
               if (bytes_left_ff == '0) begin
                  state_ff <= ST_SCAN_INIT;
               end else if (!active_ff || tail_next_in != head_ff) begin
                  if (!active_ff) begin
                     head_ff   <= '0;
                     tail_ff   <= '0;
                     active_ff <= 1'b1;
                  end else begin
                     tail_ff <= tail_next_in;
                  end
                  for (int k = 0; k < srsw_pkg::MAX_WINDOW; k++) begin
                     if (SW'(k) == (active_ff ? tail_next_in : SW'(0))) begin
                        num_ff[k]   <= next_pkt_ff[srsw_pkg::NUM_W-1:0];
                        size_ff[k]  <= pkt_size_in[srsw_pkg::SIZE_W-1:0];
                        end_ff[k]   <= (bytes_after_in == '0);
                        acked_ff[k] <= 1'b0;
                        sent_ff[k]  <= 1'b0;
                     end
                  end
                  bytes_left_ff <= bytes_after_in;
                  next_pkt_ff   <= next_pkt_ff + srsw_pkg::CNT_W'(1);
               end else begin
                  state_ff <= ST_SCAN_INIT;
               end
            end
            ST_SCAN_INIT: begin
               scan_ff  <= head_ff;
               state_ff <= active_ff ? ST_SCAN : ST_STATUS;
            end
            ST_SCAN: begin
               if (!scan_due || !rsp_full) begin
                  if (scan_due) begin
                     sent_ff[scan_ff] <= 1'b1;
                     time_ff[scan_ff] <= now_ff;
                  end
                  if (scan_ff == tail_ff) begin
                     state_ff <= ST_STATUS;
                  end else begin
                     scan_ff <= scan_next_in;
                  end
               end
            end
            ST_STATUS: begin
               if (!rsp_full) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

@@ rtl/selective_repeat_sender_window.sv @@
// selective-repeat sender window: event queue, window engine, result queue
// path to the status word: a poll or an ignored ack runs scan init, the slot scan and
// the status word; a start refills the window first, a matched ack slides and then refills
// throughput: one event at a time in the engine, two more held in the event queue;
// the scan and the status word wait while the result queue is full
// reset: synchronous, empties both queues, clears the window, registers to their defaults
module selective_repeat_sender_window (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [srsw_pkg::FUNC_W-1:0]       req_func,
   input  logic [srsw_pkg::NUM_W-1:0]        req_ack_seq,
   input  logic [srsw_pkg::TIME_W-1:0]       req_now,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic                              rsp_kind,
   output logic [srsw_pkg::NUM_W-1:0]        rsp_pkt_seq,
   output logic [srsw_pkg::SIZE_W-1:0]       rsp_pkt_len,
   output logic                              rsp_is_end,
   output logic                              rsp_retransmit,
   output logic [srsw_pkg::CNT_W-1:0]        rsp_base_number,
   output logic                              rsp_mismatch,
   output logic                              rsp_done_res,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [srsw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                       csr_data
);

   srsw_pkg::cfg_type cfg_ff;
   srsw_pkg::req_type req_word;
   srsw_pkg::rsp_type eng_word;
   srsw_pkg::rsp_type out_word;
   logic              req_valid;
   logic              req_pop;
   logic              eng_push;
   logic              rsp_full;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.win_size      <= 5'd10;
         cfg_ff.timeout_ticks <= 32'd1;
         cfg_ff.total_length  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            srsw_pkg::CSR_WINDOW_SIZE: cfg_ff.win_size      <= csr_data[4:0];
            srsw_pkg::CSR_TIMEOUT:     cfg_ff.timeout_ticks <= csr_data;
            srsw_pkg::CSR_TOTAL_LEN:   cfg_ff.total_length  <= csr_data;
            default: ;
         endcase
      end
   end

   srsw_req_q u_req_q (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .func       (req_func),
      .ack_seq    (req_ack_seq),
      .now        (req_now),
      .out_valid  (req_valid),
      .out_word   (req_word),
      .out_pop    (req_pop)
   );

   srsw_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_word  (req_word),
      .req_pop   (req_pop),
      .rsp_push  (eng_push),
      .rsp_word  (eng_word),
      .rsp_full  (rsp_full)
   );

   srsw_rsp_q u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .push     (eng_push),
      .in_word  (eng_word),
      .full     (rsp_full),
      .empty    (rsp_empty),
      .out_word (out_word),
      .pop      (rsp_pop)
   );

   assign rsp_kind          = out_word.kind;
   assign rsp_pkt_seq       = out_word.pkt_seq;
   assign rsp_pkt_len       = out_word.pkt_len;
   assign rsp_is_end        = out_word.is_end;
   assign rsp_retransmit    = out_word.retransmit;
   assign rsp_base_number   = out_word.base_number;
   assign rsp_mismatch      = out_word.mismatch;
   assign rsp_done_res      = out_word.done_res;
   assign rsp_last          = out_word.last;

endmodule
